FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the move tracker.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in the same cycle");

// Implication into the following cycle, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in the following cycle");

`endif

FILE: hw/rtl/emt_pkg.sv
// Types and constants of the encoder move tracker.
// No dependencies; imported by every module of the block.
package emt_pkg;

    localparam int COUNTS_PER_TURN = 4096;
    localparam int ANGLE_W         = 12;
    localparam int DIST_W          = 25;
    localparam int TARGET_W        = 24;
    localparam int TICK_W          = 6;
    localparam int DIFF_W          = ANGLE_W + 2;
    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 32;

    localparam logic signed [DIFF_W-1:0] HALF_TURN = DIFF_W'(COUNTS_PER_TURN / 2);
    localparam logic signed [DIFF_W-1:0] FULL_TURN = DIFF_W'(COUNTS_PER_TURN);

    localparam logic [TICK_W-1:0]   TICK_MAX     = 6'd63;
    localparam logic [TICK_W-1:0]   SETTLE_TICKS = 6'd50;
    localparam logic [TARGET_W-1:0] SMALL_TARGET = 24'd2000;
    localparam logic [TARGET_W-1:0] COAST_MARGIN = 24'd1200;
    localparam logic [DIST_W-1:0]   DIST_MAX     = '1;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_TARGET    = 2'd0;
    localparam logic [1:0] REG_DIRECTION = 2'd1;
    localparam logic [1:0] REG_WHEEL     = 2'd2;

    typedef struct packed {
        logic               mode;
        logic [ANGLE_W-1:0] position;
        logic               moving;
    } sample_t;

    typedef struct packed {
        logic               running;
        logic [DIST_W-1:0]  distance;
        logic               brake_now;
        logic [ANGLE_W-1:0] final_angle;
        logic               done_res;
        logic               start_rejected;
    } result_t;

    typedef struct packed {
        logic [TARGET_W-1:0] target_counts;
        logic                direction_reverse;
        logic                wheel_mode;
    } cfg_t;

endpackage

FILE: hw/rtl/emt_cfg.sv
// APB-style configuration registers of the move tracker.
// Depends on emt_pkg.
module emt_cfg
    import emt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [TARGET_W-1:0] target_reg;
    logic                direction_reg;
    logic                wheel_reg;
    logic                wr_en;
    logic [1:0]          reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            direction_reg <= 1'b0;
            wheel_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_TARGET:    target_reg    <= pwdata[TARGET_W-1:0];
                REG_DIRECTION: direction_reg <= pwdata[0];
                REG_WHEEL:     wheel_reg     <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_TARGET:    prdata = {{(DATA_W-TARGET_W){1'b0}}, target_reg};
            REG_DIRECTION: prdata = {{(DATA_W-1){1'b0}}, direction_reg};
            REG_WHEEL:     prdata = {{(DATA_W-1){1'b0}}, wheel_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.target_counts     = target_reg;
    assign cfg.direction_reverse = direction_reg;
    assign cfg.wheel_mode        = wheel_reg;

endmodule

FILE: hw/rtl/emt_core.sv
// Run state of the move tracker and the single-pass update for one word.
// Depends on emt_pkg.
module emt_core
    import emt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  sample_t sample,
    input  cfg_t    cfg,
    output result_t result
);

    logic                run_active_reg, run_active_next;
    logic                braking_reg, braking_next;
    logic [DIST_W-1:0]   travel_sum_reg, travel_sum_next;
    logic [ANGLE_W-1:0]  last_angle_reg, last_angle_next;
    logic [ANGLE_W-1:0]  start_angle_reg, start_angle_next;
    logic [TICK_W-1:0]   ticks_reg, ticks_next;

    logic                      tick_active;
    logic [TICK_W-1:0]         ticks_inc;
    logic signed [DIFF_W-1:0]  diff_raw, diff_wrap, diff_neg;
    logic [ANGLE_W-1:0]        step_mag;
    logic [DIST_W:0]           sum_wide;
    logic [DIST_W-1:0]         sum_sat;
    logic [TARGET_W-1:0]       margin, threshold;
    logic                      brake_fire, brake_after;
    logic [ANGLE_W-1:0]        angle_exact;

    assign tick_active = sample.mode && run_active_reg;
    assign ticks_inc   = (ticks_reg == TICK_MAX) ? ticks_reg : ticks_reg + 1'b1;

    // Unwrap the step to the nearest half turn.
    always_comb
    begin
        diff_raw = signed'({2'b00, sample.position}) - signed'({2'b00, last_angle_reg});
        if (diff_raw > HALF_TURN)
        begin
            diff_wrap = diff_raw - FULL_TURN;
        end
        else if (diff_raw < -HALF_TURN)
        begin
            diff_wrap = diff_raw + FULL_TURN;
        end
        else
        begin
            diff_wrap = diff_raw;
        end
        diff_neg = -diff_wrap;
        step_mag = diff_wrap[DIFF_W-1] ? diff_neg[ANGLE_W-1:0] : diff_wrap[ANGLE_W-1:0];
    end

    assign sum_wide  = {1'b0, travel_sum_reg} + {{(DIST_W+1-ANGLE_W){1'b0}}, step_mag};
    assign sum_sat   = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];
    assign margin    = (cfg.target_counts <= SMALL_TARGET) ?
                       {2'b00, cfg.target_counts[TARGET_W-1:2]} : COAST_MARGIN;
    assign threshold = cfg.target_counts - margin;

    assign brake_fire  = tick_active && cfg.wheel_mode && !braking_reg &&
                         (sum_sat >= {1'b0, threshold});
    assign brake_after = braking_reg || brake_fire;

    // The angle wraps within one turn, so the sum is taken modulo the word width.
    assign angle_exact = cfg.direction_reverse ?
                         start_angle_reg - cfg.target_counts[ANGLE_W-1:0] :
                         start_angle_reg + cfg.target_counts[ANGLE_W-1:0];

    always_comb
    begin
        run_active_next  = run_active_reg;
        braking_next     = braking_reg;
        travel_sum_next  = travel_sum_reg;
        last_angle_next  = last_angle_reg;
        start_angle_next = start_angle_reg;
        ticks_next       = ticks_reg;
        result.done_res  = 1'b0;
        result.start_rejected = 1'b0;

        if (!sample.mode)
        begin
            if (run_active_reg)
            begin
                result.start_rejected = 1'b1;
            end
            else
            begin
                run_active_next  = 1'b1;
                braking_next     = 1'b0;
                travel_sum_next  = '0;
                ticks_next       = '0;
                start_angle_next = sample.position;
                last_angle_next  = sample.position;
            end
        end
        else if (run_active_reg)
        begin
            ticks_next = ticks_inc;
            if (cfg.wheel_mode)
            begin
                travel_sum_next = sum_sat;
                last_angle_next = sample.position;
                braking_next    = brake_after;
                if (brake_after && !sample.moving)
                begin
                    run_active_next = 1'b0;
                    result.done_res = 1'b1;
                end
            end
            else if (!sample.moving && (ticks_inc > SETTLE_TICKS))
            begin
                run_active_next = 1'b0;
                result.done_res = 1'b1;
            end
        end

        result.running     = run_active_next;
        result.distance    = travel_sum_next;
        result.brake_now   = brake_fire;
        result.final_angle = brake_fire ? angle_exact : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg  <= 1'b0;
            braking_reg     <= 1'b0;
            travel_sum_reg  <= '0;
            last_angle_reg  <= '0;
            start_angle_reg <= '0;
            ticks_reg       <= '0;
        end
        else if (step)
        begin
            run_active_reg  <= run_active_next;
            braking_reg     <= braking_next;
            travel_sum_reg  <= travel_sum_next;
            last_angle_reg  <= last_angle_next;
            start_angle_reg <= start_angle_next;
            ticks_reg       <= ticks_next;
        end
    end

endmodule

FILE: hw/rtl/wrapped_encoder_move_tracker_top.sv
// Encoder move tracker top level: input register, update logic, result register.
// Each sample word waits in the input register until the result register can take it.
// Throughput is one word per cycle while result_stall is low.
// rst_n clears the run state, both stage valid flags and the configuration registers.
// Depends on emt_pkg, emt_cfg, emt_core and assert_macros.svh.
`include "assert_macros.svh"

module wrapped_encoder_move_tracker_top
    import emt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  sample_t           sample,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t    cfg;
    sample_t sample_reg;
    logic    in_valid_reg, in_valid_next;
    result_t result_reg;
    logic    out_valid_reg, out_valid_next;
    result_t core_result;
    logic    advance;
    logic    take;

    emt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    emt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .sample (sample_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // A word moves on whenever the result register is empty or being drained.
    assign advance      = in_valid_reg && (!out_valid_reg || !result_stall);
    assign sample_stall = in_valid_reg && out_valid_reg && result_stall;
    assign take         = sample_valid && !sample_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sample_reg <= sample;
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    `ASSERT_NEXT(a_input_held, clk, rst_n, in_valid_reg && out_valid_reg && result_stall, in_valid_reg)
    `ASSERT_SAME(a_done_ends_run, clk, rst_n, result_valid && result.done_res, !result.running)
    `ASSERT_SAME(a_reject_while_run, clk, rst_n, result_valid && result.start_rejected, result.running)
    `ASSERT_SAME(a_brake_in_run, clk, rst_n, result_valid && result.brake_now, result.running || result.done_res)

endmodule

FILE: test/move_tracker_sb_pkg.sv
// Scoreboard for the encoder move tracker testbench: a cycle-free predictor of the run state
// and a queue of awaited result words. Depends on emt_pkg for the word types and constants.
`timescale 1ns / 1ps

package move_tracker_sb_pkg;
    import emt_pkg::*;

    class move_tracker_scoreboard;
        // Register copies.
        logic [TARGET_W-1:0] target;
        logic                reverse;
        logic                wheel;

        // Run state.
        logic                active;
        logic                braking;
        logic [DIST_W-1:0]   travel;
        logic [ANGLE_W-1:0]  last_pos;
        logic [ANGLE_W-1:0]  start_pos;
        logic [TICK_W-1:0]   ticks;

        result_t awaited_results[$];
        int      errors;
        int      checked;

        function new();
            target    = '0;
            reverse   = 1'b0;
            wheel     = 1'b0;
            active    = 1'b0;
            braking   = 1'b0;
            travel    = '0;
            last_pos  = '0;
            start_pos = '0;
            ticks     = '0;
            errors    = 0;
            checked   = 0;
        endfunction

        task report(string msg);
            $display("mismatch at result word %0d: %s", checked, msg);
            errors++;
        endtask

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_TARGET:    target  = value[TARGET_W-1:0];
                REG_DIRECTION: reverse = value[0];
                REG_WHEEL:     wheel   = value[0];
                default:       ;
            endcase
        endfunction

        // Advances the run state by one accepted sample word and queues the word it yields.
        function void track_sample(sample_t s);
            result_t             r;
            int                  step;
            logic [DIST_W:0]     sum;
            logic [TARGET_W-1:0] margin;
            logic [TARGET_W-1:0] threshold;
            r = '0;
            if (!s.mode) begin
                if (active) begin
                    r.start_rejected = 1'b1;
                end
                else begin
                    active    = 1'b1;
                    braking   = 1'b0;
                    travel    = '0;
                    ticks     = '0;
                    start_pos = s.position;
                    last_pos  = s.position;
                end
            end
            else if (active) begin
                if (ticks != TICK_MAX)
                    ticks++;
                if (wheel) begin
                    // Unwrap to the nearest half turn; exactly half a turn keeps its sign.
                    step = int'(s.position) - int'(last_pos);
                    if (step > COUNTS_PER_TURN / 2)
                        step -= COUNTS_PER_TURN;
                    else if (step < -(COUNTS_PER_TURN / 2))
                        step += COUNTS_PER_TURN;
                    if (step < 0)
                        step = -step;
                    sum = {1'b0, travel} + (DIST_W+1)'(step);
                    travel = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
                    last_pos = s.position;

                    margin = (target <= SMALL_TARGET) ? (target >> 2) : COAST_MARGIN;
                    threshold = target - margin;
                    if (!braking && travel >= DIST_W'(threshold)) begin
                        braking = 1'b1;
                        r.brake_now = 1'b1;
                        r.final_angle = reverse ? start_pos - target[ANGLE_W-1:0]
                                                : start_pos + target[ANGLE_W-1:0];
                    end
                    if (braking && !s.moving) begin
                        active = 1'b0;
                        r.done_res = 1'b1;
                    end
                end
                else if (!s.moving && ticks > SETTLE_TICKS) begin
                    active = 1'b0;
                    r.done_res = 1'b1;
                end
            end
            r.running  = active;
            r.distance = travel;
            awaited_results.push_back(r);
        endfunction

        task compare_field(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s is %0h, expected %0h", field, got, want));
        endtask

        task check_result(result_t got);
            result_t want;
            if (awaited_results.size() == 0) begin
                report("result word arrived with none awaited");
                return;
            end
            want = awaited_results.pop_front();
            compare_field("running", 32'(got.running), 32'(want.running));
            compare_field("distance", 32'(got.distance), 32'(want.distance));
            compare_field("brake_now", 32'(got.brake_now), 32'(want.brake_now));
            compare_field("final_angle", 32'(got.final_angle), 32'(want.final_angle));
            compare_field("done_res", 32'(got.done_res), 32'(want.done_res));
            compare_field("start_rejected", 32'(got.start_rejected), 32'(want.start_rejected));
            checked++;
        endtask
    endclass

endpackage

FILE: test/wrapped_encoder_move_tracker_top_tb.sv
// Testbench top for the encoder move tracker: drives sample words and register writes,
// checks every result word against the scoreboard. Depends on emt_pkg and move_tracker_sb_pkg.
`timescale 1ns / 1ps

module wrapped_encoder_move_tracker_top_tb;
    import emt_pkg::*;
    import move_tracker_sb_pkg::*;

    localparam int          SAMPLE_W    = $bits(sample_t);
    localparam int          SEGMENTS    = 8;
    localparam int          SEG_ITEMS   = 180;
    localparam int          LONG_TICKS  = 40;
    localparam int          LONG_HOLD   = 300;
    localparam int unsigned CYCLE_LIMIT = 500000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              sample_valid;
    logic              sample_stall;
    sample_t           sample;
    logic              result_valid;
    logic              result_stall = 1'b0;
    result_t           result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    move_tracker_scoreboard sb;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_long      = 1'b0;
    int          seg_items      = 0;
    int unsigned cycle_count    = 0;

    wrapped_encoder_move_tracker_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge clk)
        result_stall <= hold_long || ($urandom_range(99) < recv_stall_pct);

    // Input is noted before the result is checked, so the order holds at any latency.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
                sb.track_sample(sample);
            if (result_valid && !result_stall)
                sb.check_result(result);
        end
    end

    // All driving tasks are entered and left just after a falling edge.
    task automatic send_word(input sample_t w);
        if (!w.mode || sb.active)
            seg_items++;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= w;
        do
            @(posedge clk);
        while (sample_stall);
        @(negedge clk);
    endtask

    task automatic offer(input logic m, input logic [ANGLE_W-1:0] p, input logic mv);
        sample_t w;
        w.mode     = m;
        w.position = p;
        w.moving   = mv;
        send_word(w);
    endtask

    // Stops offering words and waits until every awaited result word has come out.
    task automatic drain();
        sample_valid <= 1'b0;
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_target();
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return 32'($urandom_range(2000));
            2:       return 32'd2000 + 32'($urandom_range(1));
            default: return 32'($urandom_range(30000, 2002));
        endcase
    endfunction

    // Steps lean on the half-turn boundary where the unwrap changes sign.
    function automatic int rand_step();
        case ($urandom_range(9))
            0:       return 2048;
            1:       return -2048;
            2:       return $urandom_range(1) ? 2047 : -2047;
            3:       return int'($urandom_range(15)) - 8;
            default: return int'($urandom_range(4095)) - 2048;
        endcase
    endfunction

    function automatic logic pick_moving();
        if (!sb.wheel)
            return $urandom_range(99) >= 5;
        else if (sb.braking)
            return $urandom_range(99) >= 35;
        return $urandom_range(99) >= 12;
    endfunction

    // One run with random content, with a little noise: stray starts and odd ticks.
    task automatic random_run(input int quota);
        logic [ANGLE_W-1:0] pos;
        int                 n;
        pos = ANGLE_W'($urandom);
        offer(1'b0, pos, 1'($urandom_range(1)));
        n = 0;
        while (sb.active && n < 150 && seg_items < quota)
        begin
            n++;
            if ($urandom_range(99) < 6)
                send_word(sample_t'(SAMPLE_W'($urandom)));
            else
            begin
                pos += ANGLE_W'(rand_step());
                offer(1'b1, pos, pick_moving());
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Zero target brakes on the first tick; a second start is refused; ticks with no run
        // are ignored.
        write_reg(REG_WHEEL, 32'd1);
        offer(1'b1, 12'hFFF, 1'b1);
        offer(1'b0, 12'hFFF, 1'b0);
        offer(1'b0, 12'h000, 1'b1);
        offer(1'b1, 12'hFFF, 1'b1);
        offer(1'b1, 12'h000, 1'b0);
        drain();

        // Small target backwards: braking and stopping fall on the same tick.
        write_reg(REG_TARGET, 32'd2000);
        write_reg(REG_DIRECTION, 32'd1);
        offer(1'b0, 12'h000, 1'b1);
        offer(1'b1, 12'h800, 1'b0);
        drain();

        write_reg(REG_TARGET, 32'd2001);
        write_reg(REG_DIRECTION, 32'd0);
        offer(1'b0, 12'h800, 1'b1);
        offer(1'b1, 12'h000, 1'b1);
        offer(1'b1, 12'h7FF, 1'b1);
        offer(1'b1, 12'hFFF, 1'b0);
        drain();

        // The mode is switched while a run is in progress.
        write_reg(REG_WHEEL, 32'd0);
        offer(1'b0, 12'h123, 1'b0);
        repeat (3) offer(1'b1, 12'h123, 1'b0);
        drain();
        write_reg(REG_WHEEL, 32'd1);
        offer(1'b1, 12'h523, 1'b1);
        offer(1'b1, 12'h923, 1'b1);
        offer(1'b1, 12'h923, 1'b0);
        drain();

        // Largest target: half-turn steps stay far short of the brake point, so stopping
        // does not end the run and it is carried on into the random part.
        write_reg(REG_TARGET, 32'h00FF_FFFF);
        write_reg(REG_DIRECTION, 32'd1);
        offer(1'b0, 12'h000, 1'b1);
        for (int i = 0; i < LONG_TICKS; i++)
            offer(1'b1, (i % 2 == 0) ? 12'h800 : 12'h000, 1'b1);
        offer(1'b1, 12'h000, 1'b0);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain();
            write_reg(REG_TARGET, pick_target());
            write_reg(REG_DIRECTION, 32'($urandom_range(1)));
            write_reg(REG_WHEEL, (seg % 3 == 2) ? 32'd0 : 32'd1);
            case (seg % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 84;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 84;
                end
                default:
                begin
                    send_idle_pct  = 20;
                    recv_stall_pct = 20;
                end
            endcase
            // The receiver holds off for a long stretch while words keep coming, so the
            // block fills up and stalls its input.
            if (seg == 4)
            begin
                fork
                    begin
                        @(posedge clk);
                        hold_long = 1'b1;
                        repeat (LONG_HOLD) @(posedge clk);
                        hold_long = 1'b0;
                    end
                join_none
            end
            seg_items = 0;
            while (seg_items < SEG_ITEMS)
                random_run(SEG_ITEMS);
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
